>>> hw/rtl/spas_pkg.sv
package spas_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;

    localparam int QTR_BITS = SINE_TABLE_BITS - 2;
    localparam int QTR_SIZE = 1 << QTR_BITS;

    localparam int RATE_W  = 32;
    localparam int AMP_W   = 16;
    localparam int SR_W    = 18;
    localparam int SMAG_W  = 15;
    localparam int DIVS_W  = SR_W + 3;
    localparam int DVD_W   = PHASE_BITS + 16;
    localparam int CNT_W   = $clog2(DVD_W);
    localparam int PROD_W  = 2 * SMAG_W;

    localparam logic [SR_W-1:0]   SAMPLE_RATE_RESET = SR_W'(44100);
    localparam logic [SMAG_W-1:0] FULL_SCALE        = {SMAG_W{1'b1}};

    localparam logic [63:0] K_C1  = 64'd1686629713;
    localparam logic [63:0] K_C3  = 64'd693598668;
    localparam logic [63:0] K_C5  = 64'd85569306;
    localparam logic [63:0] K_C7  = 64'd5026995;
    localparam logic [63:0] K_C9  = 64'd172272;
    localparam logic [63:0] K_C11 = 64'd3864;

    typedef logic [PHASE_BITS-1:0] phase_t;
    typedef logic [SMAG_W-1:0]     smag_t;
    typedef smag_t                 qtr_table_t [0:QTR_SIZE];

    typedef enum logic [1:0] {
        CMD_GEN_HZ    = 2'd0,
        CMD_GEN_RPM   = 2'd1,
        CMD_SET_PHASE = 2'd2,
        CMD_RESERVED  = 2'd3
    } command_t;

    typedef enum logic {
        CFG_SAMPLE_RATE = 1'b0,
        CFG_ENABLE      = 1'b1
    } cfg_index_t;

    typedef struct packed {
        command_t                  command;
        logic [RATE_W-1:0]         rate_value;
        logic signed [AMP_W-1:0]   amplitude;
        logic [31:0]               new_phase;
        logic                      end_of_block;
    } in_item_t;

    typedef struct packed {
        logic signed [AMP_W-1:0]   left_sample;
        logic signed [AMP_W-1:0]   right_sample;
        logic                      last_of_block;
    } out_item_t;

    // Quarter-wave sine table, evaluated once at elaboration from the
    // fixed-point odd Taylor series of sin(pi/2 * x) in Q30.
    function automatic qtr_table_t build_qtr_table();
        qtr_table_t  t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] y;
        logic [63:0] v;
        for (int k = 0; k <= QTR_SIZE; k++) begin
            x  = 64'(k) << (30 - QTR_BITS);
            x2 = (x * x) >> 30;
            s  = K_C9 - ((x2 * K_C11) >> 30);
            s  = K_C7 - ((x2 * s) >> 30);
            s  = K_C5 - ((x2 * s) >> 30);
            s  = K_C3 - ((x2 * s) >> 30);
            s  = K_C1 - ((x2 * s) >> 30);
            y  = (x * s) >> 30;
            v  = (y * 64'd32767 + (64'd1 << 29)) >> 30;
            t[k] = (v > 64'd32767) ? FULL_SCALE : SMAG_W'(v);
        end
        return t;
    endfunction

    localparam qtr_table_t QTR_TABLE = build_qtr_table();

    // Places a 32-bit turn fraction into the phase word: shifted left when
    // the phase is wider, truncated from the bottom when it is narrower.
    function automatic phase_t align_phase(logic [31:0] v);
        logic [PHASE_BITS+31:0] wide;
        wide = {v, PHASE_BITS'(0)};
        return wide[PHASE_BITS+31 -: PHASE_BITS];
    endfunction

endpackage

>>> hw/rtl/sine_phase_accumulator_synth_core.sv
// Channel   Handshake               Contents
// in        in_valid / in_ready     in_data   (in_item_t: command, rate, amplitude, phase)
// out       out_valid / out_ready   out_data  (out_item_t: stereo sample, block end)
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data (sample_rate, enable)
//
// A generate transaction runs through the restoring divider (one quotient bit
// per cycle over the 48-bit dividend) and then a finishing state; the sine
// lookup and the amplitude scaling run alongside the divide.
// Set-phase and dropped transactions complete in the accept cycle.
// Reset clears the phase, enable and control state; the sample rate resets to 44100.
// A finished sample waits in the output register; the next transaction is
// taken meanwhile, and stalls before writing its own sample until that slot frees.
module sine_phase_accumulator_synth_core
    import spas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [SR_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SR_W-1:0]     sample_rate_reg;
    logic                enable_reg;
    phase_t              phase_reg;

    logic [DVD_W-1:0]    dvd_reg;
    logic [DIVS_W-1:0]   divisor_reg;
    logic [DIVS_W-1:0]   rem_reg;
    phase_t              quot_reg;

    smag_t               amag_reg;
    logic                aneg_reg;
    logic                eob_reg;
    smag_t               smag_reg;
    logic                sneg_reg;
    logic [PROD_W-1:0]   prod_reg;
    smag_t               mq_reg;
    logic [SMAG_W:0]     mr_reg;

    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic                in_fire;
    logic                is_gen;
    logic                gen_go;
    logic [AMP_W-1:0]    amp_abs;
    logic [DIVS_W-1:0]   sr_wide;
    logic [DIVS_W:0]     rem_shift;
    logic [DIVS_W+1:0]   trial;
    logic                trial_ge;
    logic [SINE_TABLE_BITS-1:0] tbl_idx;
    logic [QTR_BITS:0]   tbl_k;
    logic                out_free;
    logic [AMP_W-1:0]    mag_ext;
    logic [AMP_W-1:0]    sample_val;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign is_gen = (in_data.command == CMD_GEN_HZ) || (in_data.command == CMD_GEN_RPM);
    assign gen_go = is_gen && enable_reg && (sample_rate_reg != '0)
                    && (in_data.rate_value != '0);

    assign amp_abs = in_data.amplitude[AMP_W-1] ? (AMP_W'(0) - AMP_W'(in_data.amplitude))
                                                : AMP_W'(in_data.amplitude);
    assign sr_wide = DIVS_W'(sample_rate_reg);

    // One restoring-division step per cycle.
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, divisor_reg};
    assign trial_ge  = !trial[DIVS_W+1];

    assign tbl_idx = phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign tbl_k   = tbl_idx[QTR_BITS] ? ((QTR_BITS+1)'(QTR_SIZE) - {1'b0, tbl_idx[QTR_BITS-1:0]})
                                       : {1'b0, tbl_idx[QTR_BITS-1:0]};

    assign out_free   = !out_valid_reg || out_ready;
    assign mag_ext    = AMP_W'(mq_reg);
    assign sample_val = (aneg_reg != sneg_reg) ? (AMP_W'(0) - mag_ext) : mag_ext;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && gen_go)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            sample_rate_reg <= SAMPLE_RATE_RESET;
            enable_reg      <= 1'b0;
            phase_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SAMPLE_RATE: sample_rate_reg <= cfg_data;
                    CFG_ENABLE:      enable_reg      <= cfg_data[0];
                    default:         ;
                endcase
            end

            if (state_reg == S_IDLE)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (in_fire && (in_data.command == CMD_SET_PHASE))
            begin
                phase_reg <= align_phase(in_data.new_phase);
            end
            else if ((state_reg == S_DONE) && out_free)
            begin
                phase_reg <= phase_reg + quot_reg;
            end

            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dvd_reg     <= DVD_W'(in_data.rate_value) << (PHASE_BITS - 16);
            divisor_reg <= (in_data.command == CMD_GEN_RPM) ? ((sr_wide << 2) + (sr_wide << 1))
                                                            : sr_wide;
            rem_reg     <= '0;
            quot_reg    <= '0;
            amag_reg    <= amp_abs[AMP_W-1] ? FULL_SCALE : SMAG_W'(amp_abs);
            aneg_reg    <= in_data.amplitude[AMP_W-1];
            eob_reg     <= in_data.end_of_block;
        end
        else if (state_reg == S_DIV)
        begin
            dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg  <= trial_ge ? trial[DIVS_W-1:0] : rem_shift[DIVS_W-1:0];
            quot_reg <= {quot_reg[PHASE_BITS-2:0], trial_ge};
        end

        // Amplitude scaling runs under the divide: table read, product, then
        // division by full scale as an estimate plus up to two corrections.
        if (state_reg == S_DIV)
        begin
            if (cnt_reg == CNT_W'(0))
            begin
                smag_reg <= QTR_TABLE[tbl_k];
                sneg_reg <= tbl_idx[SINE_TABLE_BITS-1];
            end
            else if (cnt_reg == CNT_W'(1))
            begin
                prod_reg <= PROD_W'(amag_reg) * PROD_W'(smag_reg) + PROD_W'(FULL_SCALE >> 1);
            end
            else if (cnt_reg == CNT_W'(2))
            begin
                mq_reg <= prod_reg[PROD_W-1:SMAG_W];
                mr_reg <= {1'b0, prod_reg[SMAG_W-1:0]} + {1'b0, prod_reg[PROD_W-1:SMAG_W]};
            end
            else if (mr_reg >= {1'b0, FULL_SCALE})
            begin
                mr_reg <= mr_reg - {1'b0, FULL_SCALE};
                mq_reg <= mq_reg + 1'b1;
            end
        end

        if ((state_reg == S_DONE) && out_free)
        begin
            out_data_reg.left_sample   <= sample_val;
            out_data_reg.right_sample  <= sample_val;
            out_data_reg.last_of_block <= eob_reg;
        end
    end

endmodule

>>> test/spas_sample_checker.sv
`timescale 1ns / 100ps

module spas_sample_checker
    import spas_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  in_item_t        in_data,
    input  logic            out_valid,
    input  logic            out_ready,
    input  out_item_t       out_data,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  cfg_index_t      cfg_index,
    input  logic [SR_W-1:0] cfg_data,
    output int              mismatches,
    output int              pending
);

    smag_t           quarter_sine [0:QTR_SIZE];
    logic [SR_W-1:0] sample_rate_q = SAMPLE_RATE_RESET;
    logic            enabled       = 1'b0;
    phase_t          phase_acc     = '0;
    out_item_t       expected_frames [$];
    out_item_t       oldest_frame;
    out_item_t       next_frame;
    int              error_count   = 0;

    // One point of the quarter wave: odd Taylor series of sin(pi/2 * x) in Q30,
    // evaluated in Horner form with every product truncated.
    function automatic smag_t sine_point(int k);
        logic [63:0] x;
        logic [63:0] xx;
        logic [63:0] acc;
        logic [63:0] level;
        x     = 64'(k) << (30 - QTR_BITS);
        xx    = (x * x) >> 30;
        acc   = K_C9 - ((xx * K_C11) >> 30);
        acc   = K_C7 - ((xx * acc) >> 30);
        acc   = K_C5 - ((xx * acc) >> 30);
        acc   = K_C3 - ((xx * acc) >> 30);
        acc   = K_C1 - ((xx * acc) >> 30);
        level = (((x * acc) >> 30) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (level > 64'd32767)
            level = 64'd32767;
        return smag_t'(level);
    endfunction

    initial
    begin
        for (int k = 0; k <= QTR_SIZE; k++)
            quarter_sine[k] = sine_point(k);
    end

    // Updates the oscillator state for one input transaction and returns 1
    // when that transaction produces a stereo frame.
    function automatic bit predict_frame(input in_item_t item, output out_item_t frame);
        logic [PHASE_BITS+31:0]    wide;
        logic [63:0]               divisor;
        phase_t                    step;
        logic [15:0]               amp_raw;
        logic [63:0]               amp_mag;
        logic [63:0]               sine_mag;
        logic [63:0]               mag;
        logic [SINE_TABLE_BITS-1:0] point;
        logic [QTR_BITS:0]         k;
        logic                      amp_neg;
        logic                      sine_neg;
        logic [15:0]               sample;
        frame = '0;
        if (item.command == CMD_SET_PHASE)
        begin
            wide      = {item.new_phase, {PHASE_BITS{1'b0}}};
            phase_acc = wide[PHASE_BITS+31 -: PHASE_BITS];
            return 1'b0;
        end
        if (item.command == CMD_RESERVED)
            return 1'b0;
        if (!enabled || sample_rate_q == '0 || item.rate_value == '0)
            return 1'b0;

        divisor = (item.command == CMD_GEN_RPM) ? 64'(sample_rate_q) * 64'd6
                                                : 64'(sample_rate_q);
        step    = phase_t'((64'(item.rate_value) << (PHASE_BITS - 16)) / divisor);

        amp_raw = item.amplitude;
        amp_neg = amp_raw[15];
        amp_mag = amp_neg ? (64'h10000 - 64'(amp_raw)) : 64'(amp_raw);
        if (amp_mag > 64'd32767)
            amp_mag = 64'd32767;

        point    = phase_acc[PHASE_BITS-1 -: SINE_TABLE_BITS];
        k        = {1'b0, point[QTR_BITS-1:0]};
        if (point[QTR_BITS])
            k = (QTR_BITS+1)'(QTR_SIZE) - k;
        sine_neg = point[QTR_BITS+1];
        sine_mag = 64'(quarter_sine[k]);

        mag = (amp_mag * sine_mag + 64'd16383) / 64'd32767;
        if (mag > 64'd32767)
            mag = 64'd32767;
        sample = (amp_neg != sine_neg) ? 16'(64'h10000 - mag) : 16'(mag);

        frame.left_sample   = sample;
        frame.right_sample  = sample;
        frame.last_of_block = item.end_of_block;
        phase_acc = phase_acc + step;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_q = SAMPLE_RATE_RESET;
            enabled       = 1'b0;
            phase_acc     = '0;
            error_count   = 0;
            expected_frames.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: unexpected output transaction, expected none, got %p",
                             $time, out_data);
                end
                else
                begin
                    oldest_frame = expected_frames.pop_front();
                    if (out_data.left_sample !== oldest_frame.left_sample)
                    begin
                        error_count++;
                        $display("%0t ns: left_sample expected %0d, got %0d", $time,
                                 oldest_frame.left_sample, out_data.left_sample);
                    end
                    if (out_data.right_sample !== oldest_frame.right_sample)
                    begin
                        error_count++;
                        $display("%0t ns: right_sample expected %0d, got %0d", $time,
                                 oldest_frame.right_sample, out_data.right_sample);
                    end
                    if (out_data.last_of_block !== oldest_frame.last_of_block)
                    begin
                        error_count++;
                        $display("%0t ns: last_of_block expected %0b, got %0b", $time,
                                 oldest_frame.last_of_block, out_data.last_of_block);
                    end
                end
            end

            // A transaction accepted together with a register write still sees
            // the old register values.
            if (in_valid && in_ready)
            begin
                if (predict_frame(in_data, next_frame))
                    expected_frames.push_back(next_frame);
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SAMPLE_RATE: sample_rate_q = cfg_data;
                    CFG_ENABLE:      enabled       = cfg_data[0];
                    default:         ;
                endcase
            end

            mismatches <= error_count;
            pending    <= expected_frames.size();
        end
    end

endmodule

>>> test/sine_phase_accumulator_synth_core_test.sv
`timescale 1ns / 100ps

module sine_phase_accumulator_synth_core_test
    import spas_pkg::*;
();

    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_CYCLES    = 800;
    localparam int WATCHDOG_LIMIT = 5000;

    logic            clk          = 1'b0;
    logic            rst_n        = 1'b0;
    logic            in_valid;
    logic            in_ready;
    in_item_t        in_data;
    logic            out_valid;
    logic            out_ready    = 1'b0;
    out_item_t       out_data;
    logic            cfg_valid;
    logic            cfg_ready;
    cfg_index_t      cfg_index;
    logic [SR_W-1:0] cfg_data;

    int              mismatches;
    int              pending;
    int              send_idle_pct = 0;
    int              stall_pct     = 0;
    int              stuck_cycles  = 0;
    logic            hold_request  = 1'b0;
    logic            long_hold     = 1'b0;

    sine_phase_accumulator_synth_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    spas_sample_checker sample_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !long_hold && ($urandom_range(99) >= stall_pct);
    end

    // Long receiver hold-off so that the block fills and stalls its input.
    initial
    begin
        @(posedge hold_request);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    function automatic in_item_t make_item(command_t cmd, logic [31:0] rate,
                                           logic [15:0] amp, logic [31:0] ph, logic eob);
        in_item_t item;
        item.command      = cmd;
        item.rate_value   = rate;
        item.amplitude    = amp;
        item.new_phase    = ph;
        item.end_of_block = eob;
        return item;
    endfunction

    function automatic in_item_t random_item();
        int          pick;
        command_t    cmd;
        logic [31:0] rate;
        logic [15:0] amp;
        pick = $urandom_range(99);
        if (pick < 8)
            cmd = CMD_SET_PHASE;
        else if (pick < 11)
            cmd = CMD_RESERVED;
        else if (pick < 56)
            cmd = CMD_GEN_HZ;
        else
            cmd = CMD_GEN_RPM;

        pick = $urandom_range(99);
        if (pick < 40)
            rate = $urandom;
        else if (pick < 80)
            rate = $urandom_range(32'd1, 32'd20000 << 16);
        else if (pick < 90)
            rate = $urandom_range(1, 255);
        else if (pick < 95)
            rate = '0;
        else
            rate = 32'hFFFF_FFFF - $urandom_range(0, 15);

        pick = $urandom_range(99);
        if (pick < 3)
            amp = 16'h8000;
        else if (pick < 6)
            amp = 16'h8001;
        else if (pick < 9)
            amp = 16'h7FFF;
        else
            amp = 16'($urandom);
        return make_item(cmd, rate, amp, $urandom, 1'($urandom_range(1)));
    endfunction

    task automatic send_item(in_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // The checker's pending count is registered, so it lags the last accepted transaction.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [SR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Leave the block some idle cycles after the last frame before touching
    // the registers.
    task automatic configure(logic [SR_W-1:0] rate, logic en);
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(CFG_SAMPLE_RATE, rate);
        write_reg(CFG_ENABLE, SR_W'(en));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idling(int send_pct, int rx_pct);
        send_idle_pct = send_pct;
        stall_pct    <= rx_pct;
    endtask

    task automatic run_random(int count, bit pause_midway);
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                drain();
            send_item(random_item());
        end
    endtask

    initial
    begin
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SAMPLE_RATE;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset the block is disabled; set phase still acts.
        send_item(make_item(CMD_GEN_HZ, 32'd440 << 16, 16'h7FFF, '0, 1'b0));
        send_item(make_item(CMD_SET_PHASE, '0, '0, 32'h4000_0000, 1'b0));
        send_item(make_item(CMD_RESERVED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));

        configure(18'd44100, 1'b1);
        send_item(make_item(CMD_GEN_HZ, 32'd440 << 16, 16'h7FFF, '0, 1'b0));
        send_item(make_item(CMD_SET_PHASE, '0, '0, 32'h0000_0000, 1'b0));
        send_item(make_item(CMD_GEN_HZ, 32'd0, 16'h7FFF, '0, 1'b1));
        send_item(make_item(CMD_GEN_HZ, 32'hFFFF_FFFF, 16'h8000, '0, 1'b1));
        send_item(make_item(CMD_GEN_RPM, 32'hFFFF_FFFF, 16'h8001, '0, 1'b0));
        send_item(make_item(CMD_GEN_RPM, 32'd1, 16'h0000, '0, 1'b0));
        send_item(make_item(CMD_GEN_HZ, 32'd1, 16'd12345, '0, 1'b1));
        send_item(make_item(CMD_SET_PHASE, '0, '0, 32'h8000_0000, 1'b0));
        send_item(make_item(CMD_GEN_HZ, 32'd1000 << 16, 16'hFFFF, '0, 1'b0));
        send_item(make_item(CMD_SET_PHASE, '0, '0, 32'hC000_0000, 1'b0));
        send_item(make_item(CMD_GEN_HZ, 32'd1000 << 16, 16'h0001, '0, 1'b1));
        send_item(make_item(CMD_SET_PHASE, '0, '0, 32'hFFFF_FFFF, 1'b0));
        send_item(make_item(CMD_GEN_RPM, 32'd6000 << 16, 16'h7FFF, '0, 1'b0));
        send_item(make_item(CMD_SET_PHASE, '0, '0, 32'h3FC0_0000, 1'b0));
        send_item(make_item(CMD_GEN_HZ, 32'd5 << 16, 16'h8000, '0, 1'b0));
        send_item(make_item(CMD_RESERVED, 32'd440 << 16, 16'h7FFF, 32'h1234_5678, 1'b0));

        // Step below one phase unit: the same frame comes out twice.
        configure(18'd192000, 1'b1);
        send_item(make_item(CMD_SET_PHASE, '0, '0, 32'h2345_6789, 1'b0));
        send_item(make_item(CMD_GEN_HZ, 32'd1, 16'h7FFF, '0, 1'b0));
        send_item(make_item(CMD_GEN_HZ, 32'd1, 16'h7FFF, '0, 1'b1));

        // A zero sample rate behaves like a disabled block.
        configure(18'd0, 1'b1);
        send_item(make_item(CMD_GEN_HZ, 32'd440 << 16, 16'h7FFF, '0, 1'b0));
        send_item(make_item(CMD_GEN_RPM, 32'hFFFF_FFFF, 16'h7FFF, '0, 1'b1));

        configure(18'h3FFFF, 1'b1);
        send_item(make_item(CMD_GEN_RPM, 32'hFFFF_FFFF, 16'h7FFF, '0, 1'b0));

        configure(18'd1, 1'b1);
        send_item(make_item(CMD_GEN_HZ, 32'hFFFF_FFFF, 16'h7FFF, '0, 1'b1));
        send_item(make_item(CMD_GEN_RPM, 32'hFFFF_FFFF, 16'h8000, '0, 1'b0));

        set_idling(0, 0);
        configure(18'd44100, 1'b1);
        run_random(300, 1'b0);

        set_idling(57, 0);
        configure(18'd48000, 1'b1);
        run_random(250, 1'b1);

        set_idling(0, 57);
        configure(18'd192000, 1'b1);
        hold_request <= 1'b1;
        run_random(300, 1'b0);

        set_idling(21, 21);
        configure(18'($urandom_range(1, 192000)), 1'b1);
        run_random(300, 1'b0);

        set_idling(0, 0);
        configure(18'd1, 1'b1);
        run_random(120, 1'b0);

        set_idling(21, 21);
        configure(18'($urandom_range(1, 8000)), 1'b1);
        run_random(150, 1'b0);

        set_idling(57, 57);
        configure(18'd44100, 1'b0);
        run_random(40, 1'b0);

        set_idling(0, 21);
        configure(18'd96000, 1'b1);
        run_random(80, 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/spas_pkg.sv
hw/rtl/sine_phase_accumulator_synth_core.sv
test/spas_sample_checker.sv
test/sine_phase_accumulator_synth_core_test.sv
